// File: src/ttrc_pkg.sv
// types and constants shared by the three-term recurrence checksum block
package ttrc_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned TermWidth = 16;
  localparam int unsigned PosWidth  = 8;

  // product widths: (byte + alpha) is 9 bits, beta is 8 bits
  localparam int unsigned ProdWidth = TermWidth + ByteWidth + 1;
  localparam int unsigned SubWidth  = TermWidth + ByteWidth;

  localparam logic [PosWidth-1:0]  AlphaStep   = 8'd17;
  localparam logic [PosWidth-1:0]  BetaStep    = 8'd31;
  localparam logic [TermWidth-1:0] FirstOffset = 16'd7;
  localparam logic [TermWidth:0]   Modulus     = 17'd65535;
  localparam logic [TermWidth-1:0] TermReset   = 16'd1;

  // recurrence state carried from byte to byte
  typedef struct packed {
    logic [TermWidth-1:0] older;
    logic [TermWidth-1:0] newer;
    logic [PosWidth-1:0]  pos;
    logic                 start;
  } term_state_t;

  localparam term_state_t StateReset = '{
    older: TermReset,
    newer: TermReset,
    pos:   '0,
    start: 1'b1
  };

  // reduce a 25-bit value modulo 65535 by folding the upper bits onto the lower
  function automatic logic [TermWidth-1:0] fold_mod(input logic [ProdWidth-1:0] x);
    logic [TermWidth:0] sum;
    logic [TermWidth:0] red;
    sum = {1'b0, x[TermWidth-1:0]} + {{(2*TermWidth+1-ProdWidth){1'b0}}, x[ProdWidth-1:TermWidth]};
    red = (sum >= Modulus) ? (sum - Modulus) : sum;
    return red[TermWidth-1:0];
  endfunction

endpackage

// File: src/ttrc_step.sv
// one recurrence step: next state from the current state and one message byte
module ttrc_step (
  input  ttrc_pkg::term_state_t           state_i,
  input  logic [ttrc_pkg::ByteWidth-1:0]  data_byte_i,
  output ttrc_pkg::term_state_t           state_o
);
  import ttrc_pkg::*;

  logic [PosWidth-1:0]   alpha;
  logic [PosWidth-1:0]   beta;
  logic [ByteWidth:0]    factor;
  logic [ProdWidth-1:0]  prod;
  logic [ProdWidth-1:0]  sub;
  logic [ProdWidth-1:0]  diff;
  logic [TermWidth-1:0]  red;
  logic [TermWidth:0]    wrapped;
  logic [TermWidth-1:0]  term;
  logic                  neg;

  // position coefficients, both taken mod 256
  assign alpha = state_i.pos * AlphaStep;
  assign beta  = state_i.pos * BetaStep;

  // the two products of the recurrence
  assign factor = {1'b0, data_byte_i} + {1'b0, alpha};
  assign prod   = ProdWidth'(factor) * ProdWidth'(state_i.newer);
  assign sub    = {1'b0, SubWidth'(beta) * SubWidth'(state_i.older)};

  // magnitude of the difference and its residue
  assign neg  = prod < sub;
  assign diff = neg ? (sub - prod) : (prod - sub);
  assign red  = fold_mod(diff);

  // a negative difference wraps at 2^64, which is 1 mod 65535: result is (1 - red) mod 65535
  always_comb begin
    wrapped = '0;
    if (!neg) begin
      term = red;
    end else if (red <= TermReset) begin
      term = TermReset - red;
    end else begin
      wrapped = {1'b1, {TermWidth{1'b0}}} - {1'b0, red};
      term    = wrapped[TermWidth-1:0];
    end
  end

  // first byte seeds the terms, later bytes shift them
  always_comb begin
    if (state_i.start) begin
      state_o.older = TermReset;
      state_o.newer = {{(TermWidth-ByteWidth){1'b0}}, data_byte_i} + FirstOffset;
      state_o.pos   = PosWidth'(1);
      state_o.start = 1'b0;
    end else begin
      state_o.older = state_i.newer;
      state_o.newer = term;
      state_o.pos   = state_i.pos + PosWidth'(1);
      state_o.start = 1'b0;
    end
  end

endmodule

// File: src/three_term_recurrence_checksum.sv
// top level of the three-term recurrence checksum: stream handshake, state and result registers
// Takes a message one byte per transfer and gives one 16-bit checksum (0..65534) per message,
// emitted after the byte marked by tlast. The first byte seeds the terms as 1 and byte + 7;
// every later byte runs one step of (byte + alpha) * p1 - beta * p0 folded modulo 65535, with
// alpha and beta taken from the byte position. A byte is accepted every cycle unless stalled:
// it is held in an input register, the recurrence step is combinational logic from that register
// and the term registers, and the checksum lands in an output register, so the sustained rate is
// one byte per cycle; the last byte passes the input register and then the output register.
// The output register stalls the input side only when a checksum is still waiting to be taken.
module three_term_recurrence_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] checksum
);
  import ttrc_pkg::*;

  logic                 in_valid_q;
  logic                 in_valid_d;
  logic [ByteWidth-1:0] in_byte_q;
  logic                 in_last_q;
  logic                 advance;

  term_state_t          state_q;
  term_state_t          state_d;
  term_state_t          step_state;

  logic                 out_valid_q;
  logic                 out_valid_d;
  logic [TermWidth-1:0] out_data_q;

  // the held byte moves on unless it needs the output register and that is still full
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  ttrc_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .state_o     (step_state)
  );

  // input register valid
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  // next recurrence state, rearmed after the last byte
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = in_last_q ? StateReset : step_state;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload of the input register
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // payload of the output register
  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= step_state.newer;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sim/tb_top.sv
// testbench for the three-term recurrence checksum: stimulus, checksum predictor and scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttrc_pkg::*;

  // how the two sides of the stream idle during a phase
  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  // one directed byte, with a typed-in checksum where it is obvious
  typedef struct {
    logic [ByteWidth-1:0] data;
    logic                 last;
    bit                   gold_known;
    logic [TermWidth-1:0] gold;
  } stim_row_t;

  localparam int unsigned NumDirected  = 23;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned WatchdogMax  = 5000;
  localparam int unsigned DrainCycles  = 20;

  // recurrence constants, kept apart from the design's own
  localparam logic [7:0]  StepAlpha  = 8'd17;
  localparam logic [7:0]  StepBeta   = 8'd31;
  localparam logic [63:0] FoldModulo = 64'd65535;
  localparam logic [15:0] SeedOffset = 16'd7;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteWidth-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TermWidth-1:0] m_axis_tdata;

  three_term_recurrence_checksum u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor state: older and newer term, byte position, awaiting first byte
  logic [15:0] term_older = 16'd1;
  logic [15:0] term_newer = 16'd1;
  logic [7:0]  term_pos   = 8'd0;
  bit          term_start = 1'b1;

  logic [TermWidth-1:0] checksum_q[$];
  idle_mode_e           idle_mode = IdleNone;
  bit                   hold_req  = 1'b0;
  int unsigned          hold_left = 0;
  int unsigned          mismatches = 0;
  int unsigned          bytes_sent = 0;
  int unsigned          msgs_sent  = 0;
  int unsigned          long_msgs  = 0;
  int unsigned          sums_checked = 0;
  int unsigned          quiet_cycles = 0;
  stim_row_t            directed_rows [NumDirected];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void rearm_terms();
    term_older = 16'd1;
    term_newer = 16'd1;
    term_pos   = 8'd0;
    term_start = 1'b1;
  endfunction

  // advance the recurrence by one byte; returns 1 when a checksum is due
  function automatic bit checksum_step(input logic [7:0] b, input logic l,
                                       output logic [15:0] sum);
    logic [7:0]  alpha;
    logic [7:0]  beta;
    logic [63:0] prod;
    logic [63:0] sub_term;
    logic [63:0] diff;
    if (term_start) begin
      term_older = 16'd1;
      term_newer = 16'(b) + SeedOffset;
      term_pos   = 8'd1;
      term_start = 1'b0;
    end else begin
      alpha      = term_pos * StepAlpha;
      beta       = term_pos * StepBeta;
      prod       = (64'(b) + 64'(alpha)) * 64'(term_newer);
      sub_term   = 64'(beta) * 64'(term_older);
      // a negative difference wraps through 2^64 before the fold
      diff       = prod - sub_term;
      term_older = term_newer;
      term_newer = 16'(diff % FoldModulo);
      term_pos   = term_pos + 8'd1;
    end
    sum = term_newer;
    if (l) begin
      rearm_terms();
    end
    return l;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      IdleSender: return $urandom_range(0, 99) < 66;
      IdleBoth:   return $urandom_range(0, 99) < 9;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IdleReceiver: return $urandom_range(0, 99) < 66;
      IdleBoth:     return $urandom_range(0, 99) < 9;
      default:      return 1'b0;
    endcase
  endfunction

  // offer one byte at the falling edge and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic l, input bit gold_known,
                           input logic [15:0] gold);
    logic [15:0] pred;
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (checksum_step(b, l, pred)) begin
      checksum_q.push_back(gold_known ? gold : pred);
      msgs_sent++;
    end
    @(negedge clk_i);
  endtask

  // extremes often, otherwise any byte
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // whole messages of random content, opening with one long enough to wrap the position unless short_only
  task automatic send_messages(input int unsigned n_bytes, input bit short_only);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_bytes) begin
      if (!short_only && sent == 0) begin
        len = $urandom_range(257, 300);
        long_msgs++;
      end else if (short_only || $urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
      end else begin
        len = $urandom_range(1, 24);
      end
      for (int unsigned k = 0; k < len; k++) begin
        send_byte(pick_byte(), k == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  task automatic wait_drained();
    while (checksum_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !receiver_stalls();
      end
    end
  end

  // scoreboard: each checksum transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (checksum_q.size() == 0) begin
        report_mismatch($sformatf("checksum %0d with none expected", m_axis_tdata));
      end else begin
        if (m_axis_tdata !== checksum_q[0]) begin
          report_mismatch($sformatf("checksum %0d, expected %0d", m_axis_tdata,
                                    checksum_q[0]));
        end
        void'(checksum_q.pop_front());
        sums_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogMax) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WatchdogMax);
      $display("FAIL three_term_recurrence_checksum");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    directed_rows = '{
      // single-byte messages: checksum is byte + 7
      '{8'h00, 1'b1, 1'b1, 16'd7},
      '{8'hff, 1'b1, 1'b1, 16'd262},
      '{8'h80, 1'b1, 1'b1, 16'd135},
      // two-byte messages at both extremes
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b1, 1'b0, '0},
      // three bytes, alternating extremes
      '{8'h00, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b0, '0},
      // eight bytes alternating, terms grow and fold
      '{8'hff, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b0, '0},
      // mixed bits across a five-byte message
      '{8'h55, 1'b0, 1'b0, '0}, '{8'haa, 1'b0, 1'b0, '0},
      '{8'h0f, 1'b0, 1'b0, '0}, '{8'hf0, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b0, '0}
    };

    // reset, released on a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_mode = IdleNone;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].gold_known, directed_rows[i].gold);
    end

    // random messages under each idling pattern
    idle_mode = IdleNone;
    send_messages(320, 1'b0);
    idle_mode = IdleSender;
    send_messages(320, 1'b0);
    idle_mode = IdleReceiver;
    send_messages(320, 1'b0);
    idle_mode = IdleBoth;
    send_messages(320, 1'b0);

    // long receiver hold-off while short messages keep coming
    idle_mode = IdleNone;
    hold_req  = 1'b1;
    send_messages(60, 1'b1);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d bytes in %0d messages (%0d past 256 bytes), %0d checksums checked",
             bytes_sent, msgs_sent, long_msgs, sums_checked);
    $display("idling: none, sender, receiver, both, plus one %0d-cycle receiver hold-off",
             HoldCycles);
    if (mismatches == 0) begin
      $display("PASS three_term_recurrence_checksum");
    end else begin
      $display("FAIL three_term_recurrence_checksum");
    end
    $finish;
  end

endmodule
